>>> rtl/cabf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cabf_pkg
// Shared types and constants for the chunk admission byte FIFO.
// ----------------------------------------------------------------------------
package cabf_pkg;

  localparam int unsigned MEM_BYTES_DEF      = 262144;
  localparam int unsigned MAX_READ_BYTES_DEF = 64;

  localparam int unsigned CAP_W   = 19;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned LEN_W   = 19;
  localparam int unsigned WANT_W  = 16;
  localparam int unsigned FR_W    = 7;
  localparam int unsigned OVR_W   = 32;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 19'd65536;
  localparam logic [FRAME_W-1:0] FRAME_RESET = 6'd8;

  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_FRAME    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_LOST  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LOST  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FETCH,
    S_LOAD
  } state_t;

endpackage
`default_nettype wire

>>> rtl/cabf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cabf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cabf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/chunk_admission_byte_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_admission_byte_fifo
// Circular byte FIFO for capture audio with whole-chunk admission and
// frame-aligned read requests.
// ----------------------------------------------------------------------------
// Push, flush and stream-lost beats can arrive back to back. A read request
// first sizes the transfer, one subtract-and-compare step per whole frame
// returned (at most 64 frames), then reads each returned byte through the
// registered read port of the byte store, a fetch state and then a load
// state per byte, and a byte waits in load while the output stalls. Empty
// reads return a single beat. The input stalls while a read is in progress.
// ----------------------------------------------------------------------------
module chunk_admission_byte_fifo #(
  parameter int unsigned MEM_BYTES      = cabf_pkg::MEM_BYTES_DEF,
  parameter int unsigned MAX_READ_BYTES = cabf_pkg::MAX_READ_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [cabf_pkg::CAP_W-1:0]    cfg_data,

  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [1:0]                    req_type,
  input  wire logic [cabf_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          chunk_start,
  input  wire logic [cabf_pkg::LEN_W-1:0]    chunk_len,
  input  wire logic [cabf_pkg::WANT_W-1:0]   frames_wanted,

  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [1:0]                    status,
  output      logic [cabf_pkg::BYTE_W-1:0]   out_byte,
  output      logic                          is_last,
  output      logic [cabf_pkg::FR_W-1:0]     frames_read,
  output      logic [cabf_pkg::OVR_W-1:0]    overrun_count
);

  localparam int unsigned AW     = $clog2(MEM_BYTES);
  localparam int unsigned CNT_W  = $clog2(MEM_BYTES + 1);
  localparam int unsigned WIDE_W = (CNT_W > cabf_pkg::CAP_W) ? CNT_W : cabf_pkg::CAP_W;
  localparam int unsigned FR_W   = cabf_pkg::FR_W;

  cabf_pkg::state_t state, state_next;

  logic [cabf_pkg::CAP_W-1:0]   capacity_bytes, capacity_bytes_next;
  logic [cabf_pkg::FRAME_W-1:0] frame_size, frame_size_next;
  logic [AW-1:0]                read_pos, read_pos_next;
  logic [AW-1:0]                write_pos, write_pos_next;
  logic [CNT_W-1:0]             held_bytes, held_bytes_next;
  logic [cabf_pkg::OVR_W-1:0]   dropped_chunks, dropped_chunks_next;
  logic                         chunk_dropping, chunk_dropping_next;
  logic                         stream_broken, stream_broken_next;

  logic [cabf_pkg::WANT_W-1:0]  want, want_next;
  logic [FR_W-1:0]              rem, rem_next;
  logic [FR_W-1:0]              nfr, nfr_next;
  logic [FR_W-1:0]              left, left_next;
  logic [cabf_pkg::OVR_W-1:0]   ovr_hold, ovr_hold_next;

  logic                         out_valid_next;
  logic [1:0]                   status_next;
  logic [cabf_pkg::BYTE_W-1:0]  out_byte_next;
  logic                         is_last_next;
  logic [FR_W-1:0]              frames_read_next;
  logic [cabf_pkg::OVR_W-1:0]   overrun_count_next;

  logic                         ram_we;
  logic                         ram_re;
  logic [cabf_pkg::BYTE_W-1:0]  ram_rdata;

  logic [WIDE_W-1:0]            cap_wide;
  logic [CNT_W-1:0]             cap_eff;
  logic [FR_W-1:0]              fb_eff;
  logic [CNT_W-1:0]             space;
  logic [CNT_W-1:0]             read_inc;
  logic [CNT_W-1:0]             write_inc;
  logic                         in_fire;
  logic                         cfg_fire;
  logic                         out_free;

  always_comb begin
    cap_wide = WIDE_W'(capacity_bytes);
    if (cap_wide == '0) begin
      cap_wide = WIDE_W'(1);
    end else if (cap_wide > WIDE_W'(MEM_BYTES)) begin
      cap_wide = WIDE_W'(MEM_BYTES);
    end
  end

  assign cap_eff   = cap_wide[CNT_W-1:0];
  assign fb_eff    = (frame_size == '0) ? FR_W'(1) : FR_W'(frame_size);
  assign space     = cap_eff - held_bytes;
  assign read_inc  = CNT_W'(read_pos) + CNT_W'(1);
  assign write_inc = CNT_W'(write_pos) + CNT_W'(1);

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state != cabf_pkg::S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  cabf_ram #(
    .WIDTH (cabf_pkg::BYTE_W),
    .DEPTH (MEM_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (read_pos),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next          = state;
    capacity_bytes_next = capacity_bytes;
    frame_size_next     = frame_size;
    read_pos_next       = read_pos;
    write_pos_next      = write_pos;
    held_bytes_next     = held_bytes;
    dropped_chunks_next = dropped_chunks;
    chunk_dropping_next = chunk_dropping;
    stream_broken_next  = stream_broken;
    want_next           = want;
    rem_next            = rem;
    nfr_next            = nfr;
    left_next           = left;
    ovr_hold_next       = ovr_hold;
    out_valid_next      = out_valid && out_stall;
    status_next         = status;
    out_byte_next       = out_byte;
    is_last_next        = is_last;
    frames_read_next    = frames_read;
    overrun_count_next  = overrun_count;
    ram_we              = 1'b0;
    ram_re              = 1'b0;

    if (cfg_fire) begin
      if (cfg_index == cabf_pkg::CFG_CAPACITY) begin
        capacity_bytes_next = cfg_data;
        read_pos_next       = '0;
        write_pos_next      = '0;
        held_bytes_next     = '0;
      end else begin
        frame_size_next = cfg_data[cabf_pkg::FRAME_W-1:0];
      end
    end

    unique case (state)
      cabf_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (req_type)
            cabf_pkg::REQ_PUSH: begin
              if (chunk_start) begin
                if (chunk_len == '0) begin
                  chunk_dropping_next = 1'b1;
                end else if (WIDE_W'(chunk_len) > WIDE_W'(space)) begin
                  dropped_chunks_next = dropped_chunks + cabf_pkg::OVR_W'(1);
                  chunk_dropping_next = 1'b1;
                end else begin
                  chunk_dropping_next = 1'b0;
                  ram_we              = 1'b1;
                end
              end else if (!chunk_dropping) begin
                if (space == '0) begin
                  chunk_dropping_next = 1'b1;
                end else begin
                  ram_we = 1'b1;
                end
              end
              if (ram_we) begin
                held_bytes_next = held_bytes + CNT_W'(1);
                write_pos_next  = (write_inc >= cap_eff) ? '0 : write_inc[AW-1:0];
              end
            end
            cabf_pkg::REQ_READ: begin
              want_next = frames_wanted;
              rem_next  = (held_bytes > CNT_W'(MAX_READ_BYTES)) ?
                          FR_W'(MAX_READ_BYTES) : held_bytes[FR_W-1:0];
              nfr_next  = '0;
              left_next = '0;
              state_next = cabf_pkg::S_CALC;
            end
            cabf_pkg::REQ_FLUSH: begin
              read_pos_next   = '0;
              write_pos_next  = '0;
              held_bytes_next = '0;
            end
            cabf_pkg::REQ_LOST: begin
              stream_broken_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // one frame per cycle: subtract frame size from what can be returned, then fetch or send an empty beat
      cabf_pkg::S_CALC: begin
        if (rem >= fb_eff && cabf_pkg::WANT_W'(nfr) < want) begin
          rem_next  = rem - fb_eff;
          nfr_next  = nfr + FR_W'(1);
          left_next = left + fb_eff;
        end else if (left != '0) begin
          ovr_hold_next       = dropped_chunks;
          dropped_chunks_next = '0;
          state_next          = cabf_pkg::S_FETCH;
        end else if (out_free) begin
          out_valid_next     = 1'b1;
          out_byte_next      = '0;
          is_last_next       = 1'b1;
          frames_read_next   = '0;
          if (held_bytes == '0) begin
            status_next        = stream_broken ? cabf_pkg::ST_LOST : cabf_pkg::ST_EMPTY;
            overrun_count_next = '0;
          end else begin
            status_next         = cabf_pkg::ST_DATA;
            overrun_count_next  = dropped_chunks;
            dropped_chunks_next = '0;
          end
          state_next = cabf_pkg::S_IDLE;
        end
      end

      cabf_pkg::S_FETCH: begin
        ram_re     = 1'b1;
        state_next = cabf_pkg::S_LOAD;
      end

      cabf_pkg::S_LOAD: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          status_next        = cabf_pkg::ST_DATA;
          out_byte_next      = ram_rdata;
          is_last_next       = (left == FR_W'(1));
          frames_read_next   = nfr;
          overrun_count_next = ovr_hold;
          read_pos_next      = (read_inc >= cap_eff) ? '0 : read_inc[AW-1:0];
          held_bytes_next    = held_bytes - CNT_W'(1);
          left_next          = left - FR_W'(1);
          state_next         = (left == FR_W'(1)) ? cabf_pkg::S_IDLE : cabf_pkg::S_FETCH;
        end
      end

      default: begin
        state_next = cabf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= cabf_pkg::S_IDLE;
      capacity_bytes <= cabf_pkg::CAP_RESET;
      frame_size     <= cabf_pkg::FRAME_RESET;
      read_pos       <= '0;
      write_pos      <= '0;
      held_bytes     <= '0;
      dropped_chunks <= '0;
      chunk_dropping <= 1'b0;
      stream_broken  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      capacity_bytes <= capacity_bytes_next;
      frame_size     <= frame_size_next;
      read_pos       <= read_pos_next;
      write_pos      <= write_pos_next;
      held_bytes     <= held_bytes_next;
      dropped_chunks <= dropped_chunks_next;
      chunk_dropping <= chunk_dropping_next;
      stream_broken  <= stream_broken_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    want          <= want_next;
    rem           <= rem_next;
    nfr           <= nfr_next;
    left          <= left_next;
    ovr_hold      <= ovr_hold_next;
    status        <= status_next;
    out_byte      <= out_byte_next;
    is_last       <= is_last_next;
    frames_read   <= frames_read_next;
    overrun_count <= overrun_count_next;
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_chunk_admission_byte_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chunk_admission_byte_fifo
// Self-checking bench for the chunk admission byte FIFO. A short scripted
// sequence covers empty reads, zero-length and oversized chunks, partial
// frames, stream lost and flush. Randomized chunk traffic follows under
// several capacity and frame-size settings. An in-bench mirror of the FIFO
// predicts read beats (pinned script reads use fixed results). Both handshakes
// see random idle and stall cycles, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_chunk_admission_byte_fifo;

  typedef struct packed {
    cabf_pkg::status_t st;
    logic [7:0]        b;
    logic              last;
    logic [6:0]        fr;
    logic [31:0]       ovr;
  } rd_beat_t;

  typedef struct {
    cabf_pkg::req_t rq;
    logic [7:0]     d;
    logic           st;
    logic [18:0]    len;
    logic [15:0]    fw;
    bit             pinned;
    rd_beat_t       res;
  } cue_t;

  typedef struct {
    logic [18:0] cap;
    logic [18:0] frame;
    int unsigned max_len;
  } setting_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [18:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [7:0]  data_byte;
  logic        chunk_start;
  logic [18:0] chunk_len;
  logic [15:0] frames_wanted;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [7:0]  out_byte;
  logic        is_last;
  logic [6:0]  frames_read;
  logic [31:0] overrun_count;

  chunk_admission_byte_fifo uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .data_byte(data_byte), .chunk_start(chunk_start), .chunk_len(chunk_len),
    .frames_wanted(frames_wanted),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .out_byte(out_byte), .is_last(is_last), .frames_read(frames_read),
    .overrun_count(overrun_count)
  );

  // FIFO mirror
  logic [7:0]  byte_mirror [cabf_pkg::MEM_BYTES_DEF];
  int unsigned rd_pos, held, lost_chunks, capacity_reg, frame_reg;
  bit          skipping, broken;
  rd_beat_t    reads_due [$];

  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  bit          pin_on = 1'b0;
  rd_beat_t    pin_res = '0;

  cue_t script [24] = '{
    '{cabf_pkg::REQ_READ,  8'h3C, 1'b1, 19'd5,      16'd0,    1'b1,
      '{cabf_pkg::ST_EMPTY, 8'h00, 1'b1, 7'd0, 32'd0}},
    '{cabf_pkg::REQ_PUSH,  8'hFF, 1'b1, 19'd0,      16'hFFFF, 1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'hAA, 1'b0, 19'h7FFFF,  16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_READ,  8'h00, 1'b0, 19'd0,      16'hFFFF, 1'b1,
      '{cabf_pkg::ST_EMPTY, 8'h00, 1'b1, 7'd0, 32'd0}},
    '{cabf_pkg::REQ_PUSH,  8'h5A, 1'b1, 19'd262144, 16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h55, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h00, 1'b1, 19'd8,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'hFF, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h80, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h7F, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h01, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'hFE, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h55, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'hAA, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h11, 1'b1, 19'd4,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h22, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h33, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_PUSH,  8'h44, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_READ,  8'h00, 1'b0, 19'd0,      16'd0,    1'b1,
      '{cabf_pkg::ST_DATA, 8'h00, 1'b1, 7'd0, 32'd1}},
    '{cabf_pkg::REQ_READ,  8'h00, 1'b0, 19'd0,      16'hFFFF, 1'b0, '0},
    '{cabf_pkg::REQ_LOST,  8'h00, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_READ,  8'h00, 1'b0, 19'd0,      16'd1,    1'b1,
      '{cabf_pkg::ST_DATA, 8'h00, 1'b1, 7'd0, 32'd0}},
    '{cabf_pkg::REQ_FLUSH, 8'h00, 1'b0, 19'd0,      16'd0,    1'b0, '0},
    '{cabf_pkg::REQ_READ,  8'h00, 1'b0, 19'd0,      16'd2,    1'b1,
      '{cabf_pkg::ST_LOST, 8'h00, 1'b1, 7'd0, 32'd0}}
  };

  setting_t settings [6] = '{
    '{19'd24,     19'd4,  12},
    '{19'd0,      19'd0,  2},
    '{19'h7FFFF,  19'd32, 48},
    '{19'd262144, 19'd63, 48},
    '{19'd100,    19'd3,  40},
    '{19'd1,      19'd1,  3}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_chunk_admission_byte_fifo: errors");
    $finish;
  end

  function automatic void store_byte(logic [7:0] d, int unsigned cap);
    int unsigned tail;
    tail = rd_pos + held;
    if (tail >= cap) tail -= cap;
    if (tail >= cap) tail = 0;
    byte_mirror[tail % cabf_pkg::MEM_BYTES_DEF] = d;
    held++;
  endfunction

  function automatic void apply_request(logic [1:0] rq, logic [7:0] d, logic st,
                                        logic [18:0] len, logic [15:0] fw);
    int unsigned cap, space, fb, want, got, nfr, ovr;
    cap = (capacity_reg == 0) ? 1 :
          (capacity_reg > cabf_pkg::MEM_BYTES_DEF) ? cabf_pkg::MEM_BYTES_DEF :
          capacity_reg;
    if (held > cap) held = cap;
    case (rq)
      cabf_pkg::REQ_PUSH: begin
        space = cap - held;
        if (st) begin
          if (len == 0) begin
            skipping = 1'b1;
          end else if (32'(len) > space) begin
            lost_chunks++;
            skipping = 1'b1;
          end else begin
            skipping = 1'b0;
            store_byte(d, cap);
          end
        end else if (!skipping) begin
          if (space == 0) skipping = 1'b1;
          else store_byte(d, cap);
        end
      end
      cabf_pkg::REQ_FLUSH: begin
        rd_pos = 0;
        held = 0;
      end
      cabf_pkg::REQ_LOST: broken = 1'b1;
      default: begin
        if (held == 0) begin
          reads_due.push_back('{broken ? cabf_pkg::ST_LOST : cabf_pkg::ST_EMPTY,
                                8'h00, 1'b1, 7'd0, 32'd0});
        end else begin
          fb = (frame_reg == 0) ? 1 : frame_reg;
          want = 32'(fw) * fb;
          got = (held < want) ? held : want;
          if (got > cabf_pkg::MAX_READ_BYTES_DEF) got = cabf_pkg::MAX_READ_BYTES_DEF;
          got -= got % fb;
          nfr = got / fb;
          ovr = lost_chunks;
          lost_chunks = 0;
          if (got == 0) reads_due.push_back('{cabf_pkg::ST_DATA, 8'h00, 1'b1, 7'd0, ovr});
          for (int unsigned i = 0; i < got; i++) begin
            reads_due.push_back('{cabf_pkg::ST_DATA,
                                  byte_mirror[rd_pos % cabf_pkg::MEM_BYTES_DEF],
                                  i + 1 == got, nfr[6:0], ovr});
            rd_pos++;
            if (rd_pos >= cap) rd_pos = 0;
          end
          held -= got;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    rd_beat_t e;
    if (rst) begin
      rd_pos = 0;
      held = 0;
      lost_chunks = 0;
      skipping = 1'b0;
      broken = 1'b0;
      capacity_reg = 32'(cabf_pkg::CAP_RESET);
      frame_reg = 32'(cabf_pkg::FRAME_RESET);
    end else begin
      if (out_valid && !out_stall) begin
        if (reads_due.size() == 0) begin
          $error("unexpected read beat");
          mismatches++;
        end else begin
          e = reads_due.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, status);
            mismatches++;
          end
          if (out_byte !== e.b) begin
            $error("out_byte: expected %0h, got %0h", e.b, out_byte);
            mismatches++;
          end
          if (is_last !== e.last) begin
            $error("is_last: expected %0d, got %0d", e.last, is_last);
            mismatches++;
          end
          if (frames_read !== e.fr) begin
            $error("frames_read: expected %0d, got %0d", e.fr, frames_read);
            mismatches++;
          end
          if (overrun_count !== e.ovr) begin
            $error("overrun_count: expected %0d, got %0d", e.ovr, overrun_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cabf_pkg::CFG_CAPACITY) begin
          capacity_reg = 32'(cfg_data);
          rd_pos = 0;
          held = 0;
        end else begin
          frame_reg = 32'(cfg_data[5:0]);
        end
      end
      if (in_valid && !in_stall) begin
        if (pin_on) begin
          apply_request(req_type, data_byte, chunk_start, chunk_len, frames_wanted);
          void'(reads_due.pop_back());
          reads_due.push_back(pin_res);
        end else begin
          apply_request(req_type, data_byte, chunk_start, chunk_len, frames_wanted);
        end
      end
    end
  end

  // output side: random stall, or a counted hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 33);
      end
    end
  end

  task automatic put_beat(cabf_pkg::req_t rq, logic [7:0] d, logic st, logic [18:0] len,
                          logic [15:0] fw, bit pinned = 1'b0, rd_beat_t pin = '0);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pin_on = pinned;
    pin_res = pin;
    in_valid <= 1'b1;
    req_type <= rq;
    data_byte <= d;
    chunk_start <= st;
    chunk_len <= len;
    frames_wanted <= fw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(cabf_pkg::cfg_idx_t idx, logic [18:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle(int unsigned tail_cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    while (reads_due.size() != 0) @(negedge clk);
    repeat (tail_cycles) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned n, int unsigned max_len);
    int unsigned sent, pick, len, nbytes;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = $urandom_range(max_len, 1);
        if ($urandom_range(19) == 0) len = 0;
        else if ($urandom_range(19) == 0) len = $urandom_range(19'h7FFFF, 1);
        nbytes = (len == 0) ? $urandom_range(3, 1) :
                 (len > 48) ? $urandom_range(6, 1) : len;
        // truncated or overlong chunk
        if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes + 2, 1);
        put_beat(cabf_pkg::REQ_PUSH, 8'($urandom), 1'b1, len[18:0], 16'($urandom));
        repeat (nbytes - 1)
          put_beat(cabf_pkg::REQ_PUSH, 8'($urandom), 1'b0, 19'($urandom),
                   16'($urandom));
        sent += nbytes;
      end else if (pick < 88) begin
        put_beat(cabf_pkg::REQ_READ, 8'($urandom), 1'($urandom), 19'($urandom),
                 ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(12)));
        sent++;
      end else if (pick < 94) begin
        put_beat(cabf_pkg::REQ_FLUSH, 8'($urandom), 1'($urandom), 19'($urandom),
                 16'($urandom));
        sent++;
      end else if (pick < 96) begin
        put_beat(cabf_pkg::REQ_LOST, 8'($urandom), 1'($urandom), 19'($urandom),
                 16'($urandom));
        sent++;
      end else begin
        // stray continuation byte
        put_beat(cabf_pkg::REQ_PUSH, 8'($urandom), 1'b0, 19'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = cabf_pkg::REQ_PUSH;
    data_byte = '0;
    chunk_start = 1'b0;
    chunk_len = '0;
    frames_wanted = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i])
      put_beat(script[i].rq, script[i].d, script[i].st, script[i].len, script[i].fw,
               script[i].pinned, script[i].res);
    settle(20);

    foreach (settings[p]) begin
      write_reg(cabf_pkg::CFG_CAPACITY, settings[p].cap);
      write_reg(cabf_pkg::CFG_FRAME, settings[p].frame);
      no_idle = (p == 3);
      if (p == 2) hold_req = 1'b1;
      run_phase(17, settings[p].max_len);
      settle(20);
    end

    settle(100);
    if (reads_due.size() != 0) begin
      $error("read beats still outstanding: %0d", reads_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_chunk_admission_byte_fifo: clean");
    end else begin
      $display("tb_chunk_admission_byte_fifo: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cabf_pkg.sv
rtl/cabf_ram.sv
rtl/chunk_admission_byte_fifo.sv
tb/sv/tb_chunk_admission_byte_fifo.sv
